[src/lrpf_pkg.sv]
// shared types and constants of the led receiver row packet framer
// no dependencies; imported by front, queue, back end and top level
package lrpf_pkg;

    localparam int HEADER_BYTES = 21;
    localparam int IDX_W        = $clog2(HEADER_BYTES + 1);

    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // register map, index is paddr[3:2]
    localparam logic [1:0] REG_ROW_BYTES  = 2'd0;
    localparam logic [1:0] REG_ROW_COUNT  = 2'd1;
    localparam logic [1:0] REG_PACKET_MAX = 2'd2;

    localparam logic [15:0] ROW_BYTES_RST  = 16'd192;
    localparam logic [9:0]  ROW_COUNT_RST  = 10'd16;
    localparam logic [10:0] PACKET_MAX_RST = 11'd1491;
    localparam logic [9:0]  ROW_COUNT_MAX  = 10'd512;

    // header positions
    localparam logic [IDX_W-1:0] HDR_ETHER_HI = IDX_W'(12);
    localparam logic [IDX_W-1:0] HDR_ROW_HI   = IDX_W'(13);
    localparam logic [IDX_W-1:0] HDR_ROW_LO   = IDX_W'(14);
    localparam logic [IDX_W-1:0] HDR_POFF_HI  = IDX_W'(15);
    localparam logic [IDX_W-1:0] HDR_POFF_LO  = IDX_W'(16);
    localparam logic [IDX_W-1:0] HDR_PCNT_HI  = IDX_W'(17);
    localparam logic [IDX_W-1:0] HDR_PCNT_LO  = IDX_W'(18);
    localparam logic [IDX_W-1:0] HDR_TAIL0    = IDX_W'(19);
    localparam logic [IDX_W-1:0] HDR_TAIL1    = IDX_W'(20);
    localparam logic [IDX_W-1:0] HDR_PIXEL    = IDX_W'(HEADER_BYTES);

    localparam logic [7:0] ETHER_HI_BYTE = 8'h55;
    localparam logic [7:0] TAIL0_BYTE    = 8'h08;
    localparam logic [7:0] TAIL1_BYTE    = 8'h80;

    localparam logic [7:0] MAC_BYTES [12] = '{
        8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66,
        8'h22, 8'h22, 8'h33, 8'h44, 8'h55, 8'h66
    };

    // floor(len/3) for len below 2048 as (len*2731) >> 13
    localparam logic [11:0] DIV3_MUL   = 12'd2731;
    localparam int          DIV3_SHIFT = 13;

    typedef struct packed {
        logic [15:0] row_bytes;
        logic [9:0]  row_count;
        logic [10:0] packet_max;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  pixel;
        logic        hdr;
        logic [8:0]  row;
        logic [14:0] poff;
        logic [10:0] len;
        logic        pe;
        logic        fe;
    } item_t;

endpackage

[src/lrpf_front.sv]
// front end: accepts pixel beats, tracks row/offset/packet state, classifies each beat
// depends on lrpf_pkg
module lrpf_front (
    input  logic            clk,
    input  logic            rst_n,
    input  lrpf_pkg::cfg_t  cfg,
    input  logic            pixel_valid,
    output logic            pixel_stall,
    input  logic [7:0]      pixel_byte,
    output logic            push,
    output lrpf_pkg::item_t push_item,
    input  logic            q_full
);
    import lrpf_pkg::*;

    logic [8:0]  row_reg, row_next;
    logic [15:0] off_reg, off_next;
    logic [14:0] div_reg, div_next;
    logic [1:0]  mod_reg, mod_next;
    logic [10:0] left_reg, left_next;

    logic        open_pkt;
    logic        stale_off;
    logic [15:0] off_eff;
    logic [14:0] div_eff;
    logic [1:0]  mod_eff;
    logic [8:0]  row_eff;
    logic [15:0] remain;
    logic [10:0] len;
    logic [10:0] left_cur;
    logic [10:0] left_dec;
    logic [15:0] off_inc;
    logic [8:0]  row_inc;
    logic        row_end;
    logic        wrap;

    assign pixel_stall = q_full;
    assign push        = pixel_valid & ~q_full;

    always_comb
    begin
        open_pkt  = (left_reg == 11'd0);
        stale_off = open_pkt && (off_reg >= cfg.row_bytes);
        off_eff   = stale_off ? 16'd0 : off_reg;
        div_eff   = stale_off ? 15'd0 : div_reg;
        mod_eff   = stale_off ? 2'd0  : mod_reg;
        row_eff   = (open_pkt && ({1'b0, row_reg} >= cfg.row_count)) ? 9'd0 : row_reg;

        remain    = cfg.row_bytes - off_eff;
        len       = (remain < {5'd0, cfg.packet_max}) ? remain[10:0] : cfg.packet_max;
        left_cur  = open_pkt ? len : left_reg;
        left_dec  = left_cur - 11'd1;

        off_inc   = off_eff + 16'd1;
        row_end   = (off_inc >= cfg.row_bytes) || (off_inc == 16'd0);
        row_inc   = row_eff + 9'd1;
        wrap      = ({1'b0, row_inc} >= cfg.row_count) || (row_inc == 9'd0);

        if (row_end)
        begin
            off_next  = 16'd0;
            div_next  = 15'd0;
            mod_next  = 2'd0;
            left_next = 11'd0;
            row_next  = wrap ? 9'd0 : row_inc;
        end
        else
        begin
            off_next  = off_inc;
            left_next = left_dec;
            row_next  = row_eff;
            // pixel offset kept as quotient and remainder of the byte offset by three
            if (mod_eff == 2'd2)
            begin
                div_next = div_eff + 15'd1;
                mod_next = 2'd0;
            end
            else
            begin
                div_next = div_eff;
                mod_next = mod_eff + 2'd1;
            end
        end

        push_item.pixel = pixel_byte;
        push_item.hdr   = open_pkt;
        push_item.row   = row_eff;
        push_item.poff  = div_eff;
        push_item.len   = len;
        push_item.pe    = (left_dec == 11'd0) || row_end;
        push_item.fe    = row_end && wrap;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg  <= '0;
            off_reg  <= '0;
            div_reg  <= '0;
            mod_reg  <= '0;
            left_reg <= '0;
        end
        else if (push)
        begin
            row_reg  <= row_next;
            off_reg  <= off_next;
            div_reg  <= div_next;
            mod_reg  <= mod_next;
            left_reg <= left_next;
        end
    end

endmodule

[src/lrpf_queue.sv]
// short queue of classified beats between front and back end
// depends on lrpf_pkg
module lrpf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  lrpf_pkg::item_t push_item,
    output logic            full,
    input  logic            pop,
    output lrpf_pkg::item_t head,
    output logic            empty
);
    import lrpf_pkg::*;

    item_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule

[src/lrpf_back.sv]
// back end: expands a queued beat into its pixel byte, after the header bytes if it opens a packet
// depends on lrpf_pkg; the output register holds its byte and flags while wire_stall is high
module lrpf_back (
    input  logic            clk,
    input  logic            rst_n,
    input  lrpf_pkg::item_t head,
    input  logic            q_empty,
    output logic            pop,
    output logic            wire_valid,
    input  logic            wire_stall,
    output logic [7:0]      wire_byte,
    output logic            packet_end,
    output logic            frame_end,
    output logic            run_last
);
    import lrpf_pkg::*;

    logic [IDX_W-1:0] idx_reg;
    logic [9:0]       pcnt_reg;
    logic             valid_reg;
    logic [7:0]       byte_reg;
    logic             pe_reg, fe_reg, last_reg;

    logic             load;
    logic             is_pix;
    logic [22:0]      prod;
    logic [7:0]       hdr_byte;

    assign load   = !q_empty && (!valid_reg || !wire_stall);
    assign is_pix = !head.hdr || (idx_reg == HDR_PIXEL);
    assign pop    = load && is_pix;
    assign prod   = 23'(head.len) * 23'(DIV3_MUL);

    always_comb
    begin
        case (idx_reg) inside
            [IDX_W'(0):IDX_W'(11)]: hdr_byte = MAC_BYTES[idx_reg[3:0]];
            HDR_ETHER_HI:           hdr_byte = ETHER_HI_BYTE;
            HDR_ROW_HI:             hdr_byte = {7'd0, head.row[8]};
            HDR_ROW_LO:             hdr_byte = head.row[7:0];
            HDR_POFF_HI:            hdr_byte = {1'b0, head.poff[14:8]};
            HDR_POFF_LO:            hdr_byte = head.poff[7:0];
            HDR_PCNT_HI:            hdr_byte = {6'd0, pcnt_reg[9:8]};
            HDR_PCNT_LO:            hdr_byte = pcnt_reg[7:0];
            HDR_TAIL0:              hdr_byte = TAIL0_BYTE;
            HDR_TAIL1:              hdr_byte = TAIL1_BYTE;
            default:                hdr_byte = 8'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                idx_reg   <= is_pix ? '0 : idx_reg + IDX_W'(1);
            end
            else if (!wire_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        // pixel count is ready long before its header bytes go out
        if (load && head.hdr && idx_reg == '0)
            pcnt_reg <= prod[DIV3_SHIFT +: 10];
        if (load)
        begin
            byte_reg <= is_pix ? head.pixel : hdr_byte;
            pe_reg   <= is_pix && head.pe;
            fe_reg   <= is_pix && head.fe;
            last_reg <= is_pix;
        end
    end

    assign wire_valid = valid_reg;
    assign wire_byte  = byte_reg;
    assign packet_end = pe_reg;
    assign frame_end  = fe_reg;
    assign run_last   = last_reg;

endmodule

[src/led_receiver_row_packet_framer_unit.sv]
// an accepted pixel beat goes through the queue, then the output byte register
// one wire byte per cycle while wire_stall is low and a beat is queued; a beat that
// opens a packet puts out its 21 header bytes, then its pixel byte; the output register bounds the rate
// pixel beats are taken one per cycle while the 4-entry queue has room
// reset: row, offset and packet state cleared, registers at 192, 16, 1491
// top level: config registers, front end, queue, back end; depends on lrpf_pkg
module led_receiver_row_packet_framer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        pixel_valid,
    output logic        pixel_stall,
    input  logic [7:0]  pixel_byte,
    output logic        wire_valid,
    input  logic        wire_stall,
    output logic [7:0]  wire_byte,
    output logic        packet_end,
    output logic        frame_end,
    output logic        run_last
);
    import lrpf_pkg::*;

    logic [15:0] row_bytes_reg;
    logic [9:0]  row_count_reg;
    logic [10:0] packet_max_reg;
    logic        wr_en;
    logic [1:0]  reg_sel;

    cfg_t  cfg;
    logic  push, q_full, q_empty, pop;
    item_t push_item, head;

    assign pready  = 1'b1;
    assign reg_sel = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg  <= ROW_BYTES_RST;
            row_count_reg  <= ROW_COUNT_RST;
            packet_max_reg <= PACKET_MAX_RST;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_ROW_BYTES:  row_bytes_reg  <= pwdata[15:0];
                REG_ROW_COUNT:  row_count_reg  <= pwdata[9:0];
                REG_PACKET_MAX: packet_max_reg <= pwdata[10:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_ROW_BYTES:  prdata = {16'd0, row_bytes_reg};
            REG_ROW_COUNT:  prdata = {22'd0, row_count_reg};
            REG_PACKET_MAX: prdata = {21'd0, packet_max_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // zero values count as one, row count saturates at 512
    always_comb
    begin
        cfg.row_bytes  = (row_bytes_reg == 16'd0) ? 16'd1 : row_bytes_reg;
        cfg.packet_max = (packet_max_reg == 11'd0) ? 11'd1 : packet_max_reg;
        if (row_count_reg == 10'd0)
            cfg.row_count = 10'd1;
        else if (row_count_reg > ROW_COUNT_MAX)
            cfg.row_count = ROW_COUNT_MAX;
        else
            cfg.row_count = row_count_reg;
    end

    lrpf_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_byte  (pixel_byte),
        .push        (push),
        .push_item   (push_item),
        .q_full      (q_full)
    );

    lrpf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty)
    );

    lrpf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .q_empty    (q_empty),
        .pop        (pop),
        .wire_valid (wire_valid),
        .wire_stall (wire_stall),
        .wire_byte  (wire_byte),
        .packet_end (packet_end),
        .frame_end  (frame_end),
        .run_last   (run_last)
    );

endmodule

[src/lrpf_checker.sv]
// port-level checks of the row packet framer, bound to the top level
// depends only on the top level's ports
module lrpf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       pready,
    input logic       wire_valid,
    input logic       wire_stall,
    input logic [7:0] wire_byte,
    input logic       packet_end,
    input logic       frame_end,
    input logic       run_last
);

    // a stalled beat keeps its byte and flags
    assert property (@(posedge clk) disable iff (!rst_n)
        wire_valid && wire_stall |=> wire_valid && $stable(wire_byte)
            && $stable(packet_end) && $stable(frame_end) && $stable(run_last))
        else $error("stalled wire beat changed");

    // frame end only on a packet's last byte
    assert property (@(posedge clk) disable iff (!rst_n)
        wire_valid && frame_end |-> packet_end)
        else $error("frame_end without packet_end");

    // packet end only on a pixel byte, never inside a header
    assert property (@(posedge clk) disable iff (!rst_n)
        wire_valid && packet_end |-> run_last)
        else $error("packet_end on a header byte");

    // a header follows a completed packet: its first byte is the destination
    assert property (@(posedge clk) disable iff (!rst_n)
        wire_valid && !wire_stall && packet_end ##1 wire_valid && !run_last
            |-> wire_byte == 8'h11)
        else $error("header does not open with destination address");

    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready dropped");

endmodule

bind led_receiver_row_packet_framer_unit lrpf_checker u_lrpf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .pready     (pready),
    .wire_valid (wire_valid),
    .wire_stall (wire_stall),
    .wire_byte  (wire_byte),
    .packet_end (packet_end),
    .frame_end  (frame_end),
    .run_last   (run_last)
);

[tb/tb.sv]
`timescale 1ns / 100ps
// testbench of the led receiver row packet framer: drives pixel beats and config writes,
// predicts every wire byte and checks it; depends on lrpf_pkg and the framer top level
module tb;
    import lrpf_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       pkt_end;
        logic       frm_end;
        logic       last;
    } wire_beat_t;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [3:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        pixel_valid = 1'b0;
    logic        pixel_stall;
    logic [7:0]  pixel_byte  = '0;
    logic        wire_valid;
    logic        wire_stall  = 1'b0;
    logic [7:0]  wire_byte;
    logic        packet_end;
    logic        frame_end;
    logic        run_last;

    // register mirror and framing state of the predictor
    logic [15:0] cfg_row_bytes = ROW_BYTES_RST;
    logic [9:0]  cfg_row_count = ROW_COUNT_RST;
    logic [10:0] cfg_pkt_max   = PACKET_MAX_RST;
    logic [8:0]  cur_row       = '0;
    logic [15:0] cur_offset    = '0;
    logic [10:0] pkt_remaining = '0;

    logic [7:0]  pixel_backlog [$];
    wire_beat_t  wire_bytes_due [$];
    int          items_sent  = 0;
    int          items_taken = 0;
    int          wire_seen   = 0;
    int          faults      = 0;
    int          cyc         = 0;
    int          hold_left   = 0;
    bit          pressed     = 1'b0;
    logic        calm;

    led_receiver_row_packet_framer_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel_byte  (pixel_byte),
        .wire_valid  (wire_valid),
        .wire_stall  (wire_stall),
        .wire_byte   (wire_byte),
        .packet_end  (packet_end),
        .frame_end   (frame_end),
        .run_last    (run_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        cyc <= cyc + 1;

    // one long stretch where neither side idles
    assign calm = (cyc >= 2000) && (cyc < 3500);

    task automatic push_due(input logic [7:0] data, input logic pe, input logic fe,
                            input logic last);
        wire_beat_t beat;
        beat.data    = data;
        beat.pkt_end = pe;
        beat.frm_end = fe;
        beat.last    = last;
        wire_bytes_due.push_back(beat);
    endtask

    task automatic predict_wire_bytes(input logic [7:0] pix);
        int         rb;
        int         rc;
        int         pm;
        int         remain;
        int         len;
        int         poff;
        int         pcnt;
        logic       pe;
        logic       fe;
        logic [7:0] hdr [HEADER_BYTES];
        rb = (cfg_row_bytes == 0) ? 1 : int'(cfg_row_bytes);
        rc = (cfg_row_count == 0) ? 1 : int'(cfg_row_count);
        pm = (cfg_pkt_max == 0) ? 1 : int'(cfg_pkt_max);
        if (rc > int'(ROW_COUNT_MAX))
            rc = int'(ROW_COUNT_MAX);
        pe = 1'b0;
        fe = 1'b0;
        if (pkt_remaining == 0)
        begin
            // stale position after registers were lowered
            if (int'(cur_offset) >= rb)
                cur_offset = '0;
            if (int'(cur_row) >= rc)
                cur_row = '0;
            remain = rb - int'(cur_offset);
            len    = (remain < pm) ? remain : pm;
            poff   = int'(cur_offset) / 3;
            pcnt   = len / 3;
            for (int i = 0; i < 12; i++)
                hdr[i] = MAC_BYTES[i];
            hdr[12] = ETHER_HI_BYTE;
            hdr[13] = 8'(cur_row >> 8);
            hdr[14] = cur_row[7:0];
            hdr[15] = 8'(poff >> 8);
            hdr[16] = 8'(poff);
            hdr[17] = 8'(pcnt >> 8);
            hdr[18] = 8'(pcnt);
            hdr[19] = TAIL0_BYTE;
            hdr[20] = TAIL1_BYTE;
            for (int i = 0; i < HEADER_BYTES; i++)
                push_due(hdr[i], 1'b0, 1'b0, 1'b0);
            pkt_remaining = 11'(len);
        end
        pkt_remaining = pkt_remaining - 11'd1;
        cur_offset    = cur_offset + 16'd1;
        if (pkt_remaining == 0)
            pe = 1'b1;
        // row end also closes a packet left open
        if (int'(cur_offset) >= rb || cur_offset == 0)
        begin
            cur_offset    = '0;
            pkt_remaining = '0;
            pe            = 1'b1;
            cur_row       = cur_row + 9'd1;
            if (int'(cur_row) >= rc || cur_row == 0)
            begin
                cur_row = '0;
                fe      = 1'b1;
            end
        end
        push_due(pix, pe, fe, 1'b1);
    endtask

    // pixel side driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pixel_valid && !pixel_stall)
            begin
                items_taken++;
                predict_wire_bytes(pixel_byte);
            end
            if (!pixel_valid || !pixel_stall)
            begin
                if (pixel_backlog.size() != 0 && (calm || $urandom_range(99) >= 20))
                begin
                    pixel_valid <= 1'b1;
                    pixel_byte  <= pixel_backlog.pop_front();
                end
                else
                begin
                    pixel_valid <= 1'b0;
                end
            end
        end
    end

    // wire side monitor and checker
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (wire_valid && !wire_stall)
            begin
                wire_seen++;
                if (wire_bytes_due.size() == 0)
                begin
                    $display("%0t wire beat with nothing expected: byte %h", $time, wire_byte);
                    faults++;
                end
                else
                begin
                    wire_beat_t want;
                    want = wire_bytes_due.pop_front();
                    if (wire_byte !== want.data)
                    begin
                        $display("%0t wire_byte: expected %h got %h", $time, want.data,
                                 wire_byte);
                        faults++;
                    end
                    if (packet_end !== want.pkt_end)
                    begin
                        $display("%0t packet_end: expected %b got %b", $time, want.pkt_end,
                                 packet_end);
                        faults++;
                    end
                    if (frame_end !== want.frm_end)
                    begin
                        $display("%0t frame_end: expected %b got %b", $time, want.frm_end,
                                 frame_end);
                        faults++;
                    end
                    if (run_last !== want.last)
                    begin
                        $display("%0t run_last: expected %b got %b", $time, want.last,
                                 run_last);
                        faults++;
                    end
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                wire_stall <= 1'b1;
            end
            else if (!pressed && wire_seen > 300 && pixel_backlog.size() > 8)
            begin
                // long hold-off so the queue fills and the pixel side stalls
                pressed   = 1'b1;
                hold_left = 400;
                wire_stall <= 1'b1;
            end
            else
            begin
                wire_stall <= !calm && ($urandom_range(99) < 20);
            end
        end
    end

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_ROW_BYTES:  cfg_row_bytes = value[15:0];
            REG_ROW_COUNT:  cfg_row_count = value[9:0];
            REG_PACKET_MAX: cfg_pkt_max   = value[10:0];
            default: ;
        endcase
    endtask

    task automatic feed_pixels(input int count, input bit directed);
        logic [7:0] corner [4];
        corner = '{8'h00, 8'hFF, 8'h55, 8'hAA};
        for (int i = 0; i < count; i++)
        begin
            pixel_backlog.push_back(directed ? corner[(items_sent + i) % 4] : 8'($urandom));
        end
        items_sent += count;
        while (items_taken != items_sent || wire_bytes_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_random(input logic [1:0] idx, input logic [31:0] low);
        logic [31:0] upper;
        upper = $urandom;
        case (idx)
            REG_ROW_BYTES:  reg_write(idx, {upper[31:16], low[15:0]});
            REG_ROW_COUNT:  reg_write(idx, {upper[31:10], low[9:0]});
            default:        reg_write(idx, {upper[31:11], low[10:0]});
        endcase
    endtask

    initial
    begin
        int r;
        int rb;
        int rc;
        int pm;
        int n;
        bit first;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings, then a row end inside an open packet
        feed_pixels(4, 1'b1);
        reg_write(REG_ROW_BYTES, 32'd3);
        reg_write(REG_PACKET_MAX, 32'd3);
        reg_write(REG_ROW_COUNT, 32'd2);
        feed_pixels(4, 1'b1);
        reg_write(REG_ROW_COUNT, 32'd4);
        feed_pixels(3, 1'b1);
        // row number beyond the lowered row count
        reg_write(REG_ROW_COUNT, 32'd1);
        feed_pixels(3, 1'b1);
        reg_write(REG_ROW_BYTES, 32'd6);
        feed_pixels(3, 1'b1);
        // offset beyond the lowered row length
        reg_write(REG_ROW_BYTES, 32'd3);
        feed_pixels(2, 1'b1);
        // zero registers
        reg_write(REG_ROW_BYTES, 32'd0);
        reg_write(REG_ROW_COUNT, 32'd0);
        reg_write(REG_PACKET_MAX, 32'd0);
        feed_pixels(3, 1'b1);
        // field maxima, row count clamped
        reg_write(REG_ROW_BYTES, 32'hFFFF);
        reg_write(REG_ROW_COUNT, 32'h3FF);
        reg_write(REG_PACKET_MAX, 32'h7FF);
        feed_pixels(3, 1'b1);

        first = 1'b1;
        n = 0;
        while (n < 460)
        begin
            r = $urandom_range(99);
            if (r < 70)
                rb = 3 * $urandom_range(1, 20);
            else if (r < 85)
                rb = $urandom_range(1, 64);
            else if (r < 90)
                rb = 49152;
            else if (r < 95)
                rb = $urandom_range(1) ? 65535 : 3;
            else
                rb = 0;
            r = $urandom_range(99);
            if (r < 70)
                rc = $urandom_range(1, 6);
            else if (r < 85)
                rc = 512;
            else if (r < 90)
                rc = 1023;
            else if (r < 95)
                rc = 0;
            else
                rc = $urandom_range(1, 1023);
            r = $urandom_range(99);
            if (r < 60)
                pm = 3 * $urandom_range(1, 12);
            else if (r < 75)
                pm = $urandom_range(1, 40);
            else if (r < 85)
                pm = 1491;
            else if (r < 90)
                pm = 2047;
            else if (r < 95)
                pm = 0;
            else
                pm = 3;
            if (first || $urandom_range(2) != 0)
                write_random(REG_ROW_BYTES, 32'(rb));
            if (first || $urandom_range(2) != 0)
                write_random(REG_ROW_COUNT, 32'(rc));
            if (first || $urandom_range(2) != 0)
                write_random(REG_PACKET_MAX, 32'(pm));
            first = 1'b0;
            r = $urandom_range(8, 40);
            feed_pixels(r, 1'b0);
            n += r;
        end

        repeat (20) @(posedge clk);
        if (wire_bytes_due.size() != 0)
            $display("%0t wire beats never seen: %0d", $time, wire_bytes_due.size());
        if (faults == 0 && wire_bytes_due.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    initial
    begin
        #3000000;
        $display("tb: failure");
        $finish;
    end

endmodule

[files.f]
src/lrpf_pkg.sv
src/lrpf_front.sv
src/lrpf_queue.sv
src/lrpf_back.sv
src/led_receiver_row_packet_framer_unit.sv
src/lrpf_checker.sv
tb/tb.sv
